// ===== hdl/cosine_similarity_unit_macros.svh =====
// Assertion macros used by the cosine similarity unit controller.
`ifndef COSINE_SIMILARITY_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cosine similarity assertion failed");

// Next-cycle implication, disabled during reset.
`define CSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cosine similarity assertion failed");

`endif

// ===== hdl/cossim_pkg.sv =====
// Shared widths, step counts and controller/datapath command types.
`default_nettype none
package cossim_pkg;
	localparam int ELEM_W      = 16;
	localparam int ACC_W       = 38;
	localparam int SQ_PROD_W   = 31;
	localparam int PROD_W      = 2 * ACC_W;
	localparam int FRAC_SHIFT  = 30;
	localparam int REM_W       = PROD_W + FRAC_SHIFT;
	localparam int QUO_W       = 30;
	localparam int SQ_W        = 15;
	localparam int MUL_STEPS   = ACC_W;
	localparam int DIV_STEPS   = QUO_W;
	localparam int SQRT_STEPS  = SQ_W;
	localparam int CNT_W       = 6;

	typedef struct packed {
		logic acc_en;
		logic mul_load;
		logic mul_sel;
		logic mul_step;
		logic n_store;
		logic div_load;
		logic div_sat;
		logic div_step;
		logic sqrt_load;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic zero;
	} status_t;
endpackage
`default_nettype wire

// ===== hdl/cossim_if.sv =====
// Valid/ready channels for component pairs and similarity results.
`default_nettype none
interface cossim_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [cossim_pkg::ELEM_W-1:0] elem_a;
	logic signed [cossim_pkg::ELEM_W-1:0] elem_b;
	logic                                last_elem;
	modport source (output valid, elem_a, elem_b, last_elem, input ready);
	modport sink (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface cossim_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [cossim_pkg::ELEM_W-1:0] similarity;
	logic                                zero_norm;
	modport source (output valid, similarity, zero_norm, input ready);
	modport sink (input valid, similarity, zero_norm, output ready);
endinterface
`default_nettype wire

// ===== hdl/cosine_similarity_unit.sv =====
// Top level of the streaming cosine similarity unit.
// Usage:
//   item   : one component pair per transfer (elem_a, elem_b, Q2.14) with last_elem
//            marking the final pair of the two vectors.
//   result : one transfer per vector pair: similarity (Q1.15, truncated and
//            saturated) and zero_norm, set when either norm is zero (similarity 0).
// Throughput: one pair per cycle while accumulating. After the last pair the
//   input stalls through a shift-add multiply for norm_a*norm_b, another for
//   dot squared, a restoring divide, a bit-serial square root and the states
//   that sequence them. A zero norm skips from the check state straight to the
//   result state, which loads the output register once it is free.
// A new vector may start while the previous result waits to be taken, but the
//   next last pair's result waits until the output register is free.
// Reset (arst_n low, asynchronous) clears the accumulators, the sequencer and
//   the output valid; accumulators saturate on overlong vectors.
`default_nettype none
module cosine_similarity_unit (
	input  wire             clk,
	input  wire             arst_n,
	cossim_item_if.sink     item,
	cossim_result_if.source result
);
	cossim_pkg::cmd_t    cmd;
	cossim_pkg::status_t status;

	cossim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_last   (item.last_elem),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cossim_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.elem_a     (item.elem_a),
		.elem_b     (item.elem_b),
		.last_elem  (item.last_elem),
		.similarity (result.similarity),
		.zero_norm  (result.zero_norm)
	);
endmodule
`default_nettype wire

// ===== hdl/cossim_dp.sv =====
// Datapath: accumulators, shift-add multiplier, restoring divider, bit-serial square root.
`default_nettype none
module cossim_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire cossim_pkg::cmd_t               cmd,
	output cossim_pkg::status_t                 status,
	input  wire signed [cossim_pkg::ELEM_W-1:0] elem_a,
	input  wire signed [cossim_pkg::ELEM_W-1:0] elem_b,
	input  wire                                 last_elem,
	output logic signed [cossim_pkg::ELEM_W-1:0] similarity,
	output logic                                zero_norm
);
	localparam int AW = cossim_pkg::ACC_W;
	localparam int PW = cossim_pkg::PROD_W;
	localparam int RW = cossim_pkg::REM_W;
	localparam int QW = cossim_pkg::QUO_W;
	localparam int SW = cossim_pkg::SQ_W;
	localparam int EW = cossim_pkg::ELEM_W;

	logic signed [AW-1:0] dot_q;
	logic [AW-1:0]        na_q, nb_q;
	logic [AW-1:0]        nx_q, ny_q, mag_q;
	logic                 neg_q, zero_q;
	logic [PW-1:0]        mcand_q, prod_q, nval_q;
	logic [AW-1:0]        mplier_q;
	logic [RW-1:0]        rem_q, dv_q;
	logic [QW-1:0]        quo_q;
	logic                 sat_q;
	logic [SW-1:0]        sq_q, sbit_q;

	logic signed [2*EW-1:0] ab, aa_s, bb_s;
	logic signed [AW:0]     dsum;
	logic [AW:0]            asum, bsum;
	logic signed [AW-1:0]   d_next;
	logic [AW-1:0]          na_next, nb_next;
	logic [SW-1:0]          t_try;
	logic [2*SW-1:0]        t_sq;

	always_comb begin
		ab   = elem_a * elem_b;
		aa_s = elem_a * elem_a;
		bb_s = elem_b * elem_b;
		dsum = {dot_q[AW-1], dot_q} + {{(AW+1-2*EW){ab[2*EW-1]}}, ab};
		asum = {1'b0, na_q} + {{(AW+1-cossim_pkg::SQ_PROD_W){1'b0}},
			aa_s[cossim_pkg::SQ_PROD_W-1:0]};
		bsum = {1'b0, nb_q} + {{(AW+1-cossim_pkg::SQ_PROD_W){1'b0}},
			bb_s[cossim_pkg::SQ_PROD_W-1:0]};
		// clamp at the 38-bit limits instead of wrapping
		if (dsum[AW] != dsum[AW-1]) begin
			d_next = dsum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end else begin
			d_next = dsum[AW-1:0];
		end
		na_next = asum[AW] ? {AW{1'b1}} : asum[AW-1:0];
		nb_next = bsum[AW] ? {AW{1'b1}} : bsum[AW-1:0];
		t_try   = sq_q | sbit_q;
		t_sq    = t_try * t_try;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (cmd.acc_en) begin
			if (last_elem) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				dot_q <= d_next;
				na_q  <= na_next;
				nb_q  <= nb_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en && last_elem) begin
			nx_q   <= na_next;
			ny_q   <= nb_next;
			neg_q  <= d_next[AW-1];
			mag_q  <= d_next[AW-1] ? AW'(-d_next) : AW'(d_next);
			zero_q <= (na_next == '0) || (nb_next == '0);
		end
		if (cmd.mul_load) begin
			mcand_q  <= {{(PW-AW){1'b0}}, (cmd.mul_sel ? mag_q : nx_q)};
			mplier_q <= cmd.mul_sel ? mag_q : ny_q;
			prod_q   <= '0;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) prod_q <= prod_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.n_store) nval_q <= prod_q;
		if (cmd.div_load) begin
			rem_q <= {prod_q, {cossim_pkg::FRAC_SHIFT{1'b0}}};
			dv_q  <= {nval_q, {cossim_pkg::FRAC_SHIFT{1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_sat) begin
			sat_q <= rem_q >= dv_q;
			dv_q  <= dv_q >> 1;
		end else if (cmd.div_step) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dv_q <= dv_q >> 1;
		end
		if (cmd.sqrt_load) begin
			sq_q   <= '0;
			sbit_q <= {1'b1, {(SW-1){1'b0}}};
		end else if (cmd.sqrt_step) begin
			if (t_sq <= quo_q) sq_q <= t_try;
			sbit_q <= sbit_q >> 1;
		end
		if (cmd.out_load) begin
			zero_norm <= zero_q;
			if (zero_q) begin
				similarity <= '0;
			end else if (sat_q) begin
				similarity <= neg_q ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
			end else begin
				similarity <= neg_q ? -$signed({1'b0, sq_q}) : $signed({1'b0, sq_q});
			end
		end
	end

	assign status.zero = zero_q;
endmodule
`default_nettype wire

// ===== hdl/cossim_ctrl.sv =====
// Controller: sequences accumulation, multiply, divide, square root and result hand-off.
`default_nettype none
`include "cosine_similarity_unit_macros.svh"
module cossim_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire                       in_last,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire                       out_ready,
	input  wire cossim_pkg::status_t  status,
	output cossim_pkg::cmd_t          cmd
);
	localparam int CW = cossim_pkg::CNT_W;
	localparam logic [3:0] ST_ACC  = 4'd0;
	localparam logic [3:0] ST_CHK  = 4'd1;
	localparam logic [3:0] ST_MULN = 4'd2;
	localparam logic [3:0] ST_MLDR = 4'd3;
	localparam logic [3:0] ST_MULR = 4'd4;
	localparam logic [3:0] ST_DLD  = 4'd5;
	localparam logic [3:0] ST_DSAT = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_SLD  = 4'd8;
	localparam logic [3:0] ST_SQRT = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;
	localparam logic [CW-1:0] MUL_LAST  = CW'(cossim_pkg::MUL_STEPS - 1);
	localparam logic [CW-1:0] DIV_LAST  = CW'(cossim_pkg::DIV_STEPS - 1);
	localparam logic [CW-1:0] SQRT_LAST = CW'(cossim_pkg::SQRT_STEPS - 1);

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_ACC: begin
				in_ready   = 1'b1;
				cmd.acc_en = in_valid;
				if (in_valid && in_last) state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.mul_load = 1'b1;
				cnt_d        = '0;
				state_d      = status.zero ? ST_FIN : ST_MULN;
			end
			ST_MULN: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = ST_MLDR;
				end
			end
			ST_MLDR: begin
				cmd.n_store  = 1'b1;
				cmd.mul_load = 1'b1;
				cmd.mul_sel  = 1'b1;
				state_d      = ST_MULR;
			end
			ST_MULR: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = ST_DLD;
				end
			end
			ST_DLD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DSAT;
			end
			ST_DSAT: begin
				cmd.div_sat = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = ST_SLD;
				end
			end
			ST_SLD: begin
				cmd.sqrt_load = 1'b1;
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`CSU_ASSERT_NOW(a_ready_only_acc, in_ready, state_q == ST_ACC)
	`CSU_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && in_last, !in_ready)
	`CSU_ASSERT_NOW(a_load_from_fin, cmd.out_load, state_q == ST_FIN)
	`CSU_ASSERT_NEXT(a_result_after_load, cmd.out_load, out_valid)
endmodule
`default_nettype wire
